[sv/pvt_pkg.sv]
package pvt_pkg;

   localparam int unsigned CoordWidth = 32;
   localparam int unsigned PerimWidth = 39;
   localparam int unsigned RootWidth = 34;

   typedef enum logic [1:0] {
      STATUS_ADDED     = 2'd0,
      STATUS_DUPLICATE = 2'd1,
      STATUS_NO_EDGE   = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CMD_APPEND = 1'b0,
      CMD_INSERT = 1'b1
   } command_type;

   typedef struct packed {
      logic [CoordWidth-1:0] x;
      logic [CoordWidth-1:0] y;
   } point_type;

   // handshake between the sequencer and the edge length unit
   typedef struct packed {
      logic start;
      logic [CoordWidth-1:0] dx;
      logic [CoordWidth-1:0] dy;
   } len_req_type;

   typedef struct packed {
      logic done;
      logic [RootWidth-1:0] root;
   } len_rsp_type;

endpackage

[sv/polygon_vertex_table_perimeter_core.sv]
// sequence: the duplicate scan reads the stored vertices, an insert adds an edge scan and
// shifts each vertex from the insert point up by one, then the perimeter walk sends every
// edge through the iterative root unit; the strobe comes last.
// one word at a time: busy stays high until rsp_valid; results cannot be stalled.
// reset (synchronous, active high) empties the table and clears the perimeter;
// the vertex memory itself is not cleared.
module polygon_vertex_table_perimeter_core #(
   parameter int unsigned MAX_VERTICES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic signed [31:0] req_new_x,
   input  logic signed [31:0] req_new_y,
   input  logic signed [31:0] req_edge_ax,
   input  logic signed [31:0] req_edge_ay,
   input  logic signed [31:0] req_edge_bx,
   input  logic signed [31:0] req_edge_by,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_vertex_total,
   output logic [38:0] rsp_perimeter_out
);

   localparam int unsigned AW = $clog2(MAX_VERTICES);
   localparam int unsigned NW = $clog2(MAX_VERTICES + 1);
   localparam int unsigned PW = pvt_pkg::PerimWidth;
   localparam int unsigned CW = pvt_pkg::CoordWidth;
   localparam logic [PW-1:0] PerimMax = '1;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_DUPRD = 10'b0000000010,
      S_DUPCK = 10'b0000000100,
      S_EDGRD = 10'b0000001000,
      S_EDGCK = 10'b0000010000,
      S_SHRD  = 10'b0000100000,
      S_SHWR  = 10'b0001000000,
      S_PRD   = 10'b0010000000,
      S_PLEN  = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [NW-1:0] count_ff, count_in;
   logic [PW-1:0] perim_ff, perim_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic [NW-1:0] pos_ff, pos_in;
   logic [1:0] status_ff, status_in;
   logic cmd_ff;
   pvt_pkg::point_type p_ff, a_ff, b_ff;
   pvt_pkg::point_type prev_ff, prev_in;
   logic prev_a_ff, prev_a_in, prev_b_ff, prev_b_in;
   logic first_a_ff, first_a_in, first_b_ff, first_b_in;
   logic rsp_valid_ff;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   pvt_pkg::point_type wr_data, rd_data;
   pvt_pkg::len_req_type len_req;
   pvt_pkg::len_rsp_type len_rsp;
   logic [PW:0] sum_w;
   logic [CW:0] ddx, ddy;
   logic cur_a, cur_b;

   pvt_ram #(.Width(2 * CW), .Depth(MAX_VERTICES)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   pvt_edge_len u_len (.clock(clock), .reset(reset), .len_req(len_req), .len_rsp(len_rsp));

   assign cur_a = rd_data == a_ff;
   assign cur_b = rd_data == b_ff;
   // signed differences of current and previous word
   assign ddx = {prev_ff.x[CW-1], prev_ff.x} - {rd_data.x[CW-1], rd_data.x};
   assign ddy = {prev_ff.y[CW-1], prev_ff.y} - {rd_data.y[CW-1], rd_data.y};
   assign sum_w = {1'b0, acc_ff} + (PW+1)'(len_rsp.root);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      perim_in = perim_ff;
      acc_in = acc_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      status_in = status_ff;
      prev_in = prev_ff;
      prev_a_in = prev_a_ff;
      prev_b_in = prev_b_ff;
      first_a_in = first_a_ff;
      first_b_in = first_b_ff;
      wr_en = 1'b0;
      wr_addr = AW'(idx_ff);
      wr_data = p_ff;
      rd_addr = AW'(idx_ff);
      len_req.start = 1'b0;
      len_req.dx = ddx[CW] ? CW'(-ddx) : ddx[CW-1:0];
      len_req.dy = ddy[CW] ? CW'(-ddy) : ddy[CW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               idx_in = '0;
               status_in = pvt_pkg::STATUS_ADDED;
               pos_in = count_ff;
               state_in = S_DUPRD;
            end
         end
         S_DUPRD: begin
            if (idx_ff == count_ff) begin
               state_in = (cmd_ff == pvt_pkg::CMD_INSERT) ? S_EDGRD : S_SHRD;
               idx_in = '0;
            end else begin
               state_in = S_DUPCK;
            end
         end
         S_DUPCK: begin
            if (rd_data == p_ff) begin
               status_in = pvt_pkg::STATUS_DUPLICATE;
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_DUPRD;
            end
         end
         S_EDGRD: begin
            if (idx_ff == count_ff) begin
               // closing edge: last vertex back to the first
               if (count_ff != '0 &&
                   ((prev_a_ff && first_b_ff) || (prev_b_ff && first_a_ff))) begin
                  pos_in = count_ff;
                  idx_in = count_ff;
                  state_in = S_SHRD;
               end else begin
                  status_in = pvt_pkg::STATUS_NO_EDGE;
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_EDGCK;
            end
         end
         S_EDGCK: begin
            if (idx_ff != '0 && ((prev_a_ff && cur_b) || (prev_b_ff && cur_a))) begin
               pos_in = idx_ff;
               idx_in = count_ff;
               state_in = S_SHRD;
            end else begin
               if (idx_ff == '0) begin
                  first_a_in = cur_a;
                  first_b_in = cur_b;
               end
               prev_a_in = cur_a;
               prev_b_in = cur_b;
               idx_in = idx_ff + 1'b1;
               state_in = S_EDGRD;
            end
         end
         S_SHRD: begin
            if (count_ff >= NW'(MAX_VERTICES)) begin
               status_in = pvt_pkg::STATUS_FULL;
               state_in = S_DONE;
            end else if (idx_ff == pos_ff || cmd_ff == pvt_pkg::CMD_APPEND) begin
               wr_en = 1'b1;
               wr_addr = AW'(pos_ff);
               count_in = count_ff + 1'b1;
               idx_in = '0;
               acc_in = '0;
               state_in = S_PRD;
            end else begin
               rd_addr = AW'(idx_ff - 1'b1);
               state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            wr_en = 1'b1;
            wr_data = rd_data;
            idx_in = idx_ff - 1'b1;
            state_in = S_SHRD;
         end
         S_PRD: begin
            // read vertex idx (wrapping to 0 at the end)
            rd_addr = (idx_ff == count_ff) ? '0 : AW'(idx_ff);
            state_in = S_PLEN;
         end
         S_PLEN: begin
            if (idx_ff == '0) begin
               prev_in = rd_data;
               idx_in = NW'(1);
               state_in = S_PRD;
            end else if (len_rsp.done) begin
               acc_in = sum_w[PW] ? PerimMax : sum_w[PW-1:0];
               prev_in = rd_data;
               if (idx_ff == count_ff) begin
                  perim_in = sum_w[PW] ? PerimMax : sum_w[PW-1:0];
                  state_in = S_DONE;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = S_PRD;
               end
            end else begin
               len_req.start = 1'b1;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         perim_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         perim_ff <= perim_in;
         rsp_valid_ff <= state_ff == S_DONE;
      end
      if (state_ff == S_IDLE && start) begin
         cmd_ff <= req_command;
         p_ff <= {req_new_x, req_new_y};
         a_ff <= {req_edge_ax, req_edge_ay};
         b_ff <= {req_edge_bx, req_edge_by};
      end
      acc_ff <= acc_in;
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      status_ff <= status_in;
      prev_ff <= prev_in;
      prev_a_ff <= prev_a_in;
      prev_b_ff <= prev_b_in;
      first_a_ff <= first_a_in;
      first_b_ff <= first_b_in;
   end

   assign busy = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_vertex_total = 7'(count_ff);
   assign rsp_perimeter_out = perim_ff;

   count_bound_a: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(MAX_VERTICES))
      else $error("vertex count beyond table size");

   reject_keeps_a: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && status_ff != pvt_pkg::STATUS_ADDED) |-> $stable(count_ff))
      else $error("rejected word changed the table");

   valid_pulse_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule

[sv/pvt_ram.sv]
module pvt_ram #(
   parameter int unsigned Width = 64,
   parameter int unsigned Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[sv/pvt_edge_len.sv]
module pvt_edge_len (
   input  logic                 clock,
   input  logic                 reset,
   input  pvt_pkg::len_req_type len_req,
   output pvt_pkg::len_rsp_type len_rsp
);

   localparam int unsigned RW = pvt_pkg::RootWidth;
   localparam int unsigned SW = 2 * RW;
   localparam int unsigned CW = pvt_pkg::CoordWidth;

   typedef enum logic [3:0] {
      L_IDLE = 4'b0001,
      L_SQX  = 4'b0010,
      L_SQY  = 4'b0100,
      L_ROOT = 4'b1000
   } len_state_type;

   len_state_type state_ff, state_in;
   logic [CW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [RW-1:0] root_ff, root_in;
   logic [$clog2(RW)-1:0] step_ff, step_in;
   logic [CW-1:0] sq_op;
   logic [2*CW-1:0] sq_prod;
   logic [SW-1:0] sq;
   logic [SW-1:0] rem_sh;
   logic [RW+1:0] trial;
   logic [RW+1:0] rtop;
   logic [RW+1:0] tsub;

   // one 32x32 square per cycle
   assign sq_op = (state_ff == L_SQX) ? dx_ff : dy_ff;
   assign sq_prod = sq_op * sq_op;
   assign sq = SW'(sq_prod);

   // restoring square root, one result bit per cycle over the 68 bit radicand
   always_comb begin
      rtop = (RW+2)'(rem_ff >> (2 * step_ff));
      trial = {root_ff, 2'b01};
      tsub = rtop - trial;
      rem_sh = '0;
   end

   always_comb begin
      state_in = state_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      len_rsp.done = 1'b0;
      len_rsp.root = root_ff;
      case (state_ff)
         L_IDLE: begin
            if (len_req.start) begin
               dx_in = len_req.dx;
               dy_in = len_req.dy;
               state_in = L_SQX;
            end
         end
         L_SQX: begin
            rem_in = sq;
            state_in = L_SQY;
         end
         L_SQY: begin
            rem_in = rem_ff + sq;
            root_in = '0;
            step_in = ($clog2(RW))'(RW - 1);
            state_in = L_ROOT;
         end
         L_ROOT: begin
            root_in = {root_ff[RW-2:0], 1'b0};
            if (rtop >= trial) begin
               rem_in = rem_ff - (SW'(trial) << (2 * step_ff));
               root_in = {root_ff[RW-2:0], 1'b1};
            end
            if (step_ff == '0) begin
               state_in = L_IDLE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         default: state_in = L_IDLE;
      endcase
      if (state_ff == L_ROOT && step_ff == '0) begin
         len_rsp.done = 1'b1;
         len_rsp.root = root_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      rem_ff <= rem_in | rem_sh;
      root_ff <= root_in;
      step_ff <= step_in;
   end

   unused_tsub_a: assert property (@(posedge clock) disable iff (reset)
      (state_ff == L_ROOT && rtop >= trial) |-> (tsub <= rtop))
      else $error("root trial subtract wrapped");

   done_root_a: assert property (@(posedge clock) disable iff (reset)
      len_rsp.done |=> state_ff == L_IDLE)
      else $error("length unit did not return to idle");

   start_idle_a: assert property (@(posedge clock) disable iff (reset)
      (state_ff == L_IDLE && len_req.start) |=> state_ff == L_SQX)
      else $error("length unit missed a start");

endmodule
